// File: hw/rtl/anp_pkg.sv
package anp_pkg;

   // ASCII codes used by the parser
   localparam logic [7:0] CH_NUL        = 8'h00;
   localparam logic [7:0] CH_ZERO       = 8'h30;
   localparam logic [7:0] CH_LETTER_OFS = 8'h37;
   localparam logic [7:0] CH_UPPER_X    = 8'h58;
   localparam logic [7:0] CH_MINUS      = 8'h2D;
   localparam logic [7:0] CH_PLUS       = 8'h2B;
   localparam logic [7:0] BIT5          = 8'h20;

   // one request as held in the input register
   typedef struct packed {
      logic       valid;
      logic       last;
      logic [7:0] char_code;
   } anp_stage_type;

   // fold a..z to A..Z by clearing bit 5
   function automatic logic [7:0] fold_upper(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c inside {[8'h61:8'h7A]}) r = c & ~BIT5;
      return r;
   endfunction

endpackage

// File: hw/rtl/anp_in_reg.sv
module anp_in_reg
   import anp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic [7:0]    req_char_in,
   input  logic          req_is_last,
   input  logic          advance,
   output anp_stage_type stage
);

   logic       valid_ff, valid_in;
   logic       last_ff, last_in;
   logic [7:0] char_ff, char_in;

   // register is free when empty or when the core drains it this cycle
   assign req_ready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      last_in  = last_ff;
      char_in  = char_ff;
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
         last_in  = req_is_last;
         char_in  = req_char_in;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      last_ff <= last_in;
      char_ff <= char_in;
   end

   assign stage.valid     = valid_ff;
   assign stage.last      = last_ff;
   assign stage.char_code = char_ff;

endmodule

// File: hw/rtl/anp_core.sv
module anp_core
   import anp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  anp_stage_type stage,
   output logic          advance,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic [31:0]   rsp_value
);

   typedef enum logic [2:0] {
      PH_ZEROS,
      PH_HEX,
      PH_SIGN,
      PH_DEC,
      PH_ENDED,
      PH_INVALID
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [31:0] acc_ff, acc_in;
   logic        neg_ff, neg_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_value_ff, rsp_value_in;

   logic [7:0]  c;
   logic [3:0]  dec_digit;
   logic [3:0]  hex_nibble;
   logic        is_dec, is_hex;
   logic [31:0] digit_term;
   logic [31:0] dec_acc;
   logic [31:0] hex_acc;

   // the stage moves whenever the result register is free
   assign advance = !rsp_valid_ff || rsp_ready;

   // character classification
   always_comb begin
      c          = fold_upper(stage.char_code);
      is_dec     = c inside {[8'h30:8'h39]};
      is_hex     = is_dec || (c inside {[8'h41:8'h46]});
      dec_digit  = 4'(c - CH_ZERO);
      hex_nibble = (c < 8'h41) ? 4'(c - CH_ZERO) : 4'(c - CH_LETTER_OFS);
   end

   // accumulator is kept already signed: a negative number subtracts digits
   always_comb begin
      digit_term = neg_ff ? (32'd0 - {28'd0, dec_digit}) : {28'd0, dec_digit};
      dec_acc    = {acc_ff[28:0], 3'b000} + {acc_ff[30:0], 1'b0} + digit_term;
      hex_acc    = {acc_ff[27:0], hex_nibble};
   end

   // parse state update
   always_comb begin
      phase_in = phase_ff;
      acc_in   = acc_ff;
      neg_in   = neg_ff;
      if (phase_ff != PH_ENDED && phase_ff != PH_INVALID) begin
         if (stage.char_code == CH_NUL) begin
            phase_in = PH_ENDED;
         end else begin
            case (phase_ff)
               PH_ZEROS, PH_SIGN, PH_DEC: begin
                  if (phase_ff == PH_ZEROS && c == CH_ZERO) begin
                     // skip leading zero
                  end else if (phase_ff == PH_ZEROS && c == CH_UPPER_X) begin
                     phase_in = PH_HEX;
                  end else if (phase_ff == PH_ZEROS && c == CH_MINUS) begin
                     neg_in   = 1'b1;
                     phase_in = PH_SIGN;
                  end else if (phase_ff != PH_DEC && c == CH_PLUS) begin
                     neg_in   = 1'b0;
                     phase_in = PH_DEC;
                  end else if (is_dec) begin
                     acc_in   = dec_acc;
                     phase_in = PH_DEC;
                  end else begin
                     phase_in = PH_INVALID;
                     acc_in   = 32'd0;
                     neg_in   = 1'b0;
                  end
               end
               PH_HEX: begin
                  if (is_hex) begin
                     acc_in = hex_acc;
                  end else begin
                     phase_in = PH_INVALID;
                     acc_in   = 32'd0;
                     neg_in   = 1'b0;
                  end
               end
               default: begin
                  phase_in = PH_INVALID;
                  acc_in   = 32'd0;
                  neg_in   = 1'b0;
               end
            endcase
         end
      end
   end

   // result register and end-of-string restart
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      if (advance && stage.valid && stage.last) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = acc_in;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_ZEROS;
         acc_ff       <= 32'd0;
         neg_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (advance && stage.valid) begin
            if (stage.last) begin
               phase_ff <= PH_ZEROS;
               acc_ff   <= 32'd0;
               neg_ff   <= 1'b0;
            end else begin
               phase_ff <= phase_in;
               acc_ff   <= acc_in;
               neg_ff   <= neg_in;
            end
         end
      end
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;

endmodule

// File: hw/rtl/ascii_number_parser_top.sv
// ASCII number parser: one character per request, result on the last one.
// A last character passes through the input register, then the parse update
// writes its result into the result register; a stalled result holds it back.
// Throughput: one character per cycle unless the result register stalls;
// the parse state and the shift-add accumulator update once per character.
// Reset (synchronous, active high) empties both registers and restarts parsing.
module ascii_number_parser_top
   import anp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_char_in,
   input  logic               req_is_last,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_value
);

   anp_stage_type stage;
   logic          advance;
   logic [31:0]   value_raw;

   // input register
   anp_in_reg u_in_reg (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_char_in (req_char_in),
      .req_is_last (req_is_last),
      .advance     (advance),
      .stage       (stage)
   );

   // parse state and result register
   anp_core u_core (
      .clock     (clock),
      .reset     (reset),
      .stage     (stage),
      .advance   (advance),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_value (value_raw)
   );

   assign rsp_value = signed'(value_raw);

   // an empty input register always takes a request
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !stage.valid |-> req_ready)
      else $error("input register empty but request not taken");

   // a last character that moves on produces a result next cycle
   a_last_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      (stage.valid && stage.last && advance) |=> rsp_valid)
      else $error("last character did not produce a result");

   // a stalled result blocks the input register from draining
   a_stall_holds_stage: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready && stage.valid) |=> stage.valid)
      else $error("input register drained while result stalled");

   // no result is pending right after reset
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule
